/* rtl/utx_pkg.sv */
// Shared types and constants for the 8N1 serial transmitter with byte queue.
`default_nettype none
package utx_pkg;

	// Frame register: eight data bits, stop bit, and a sentinel above them.
	localparam int unsigned FRAME_W  = 10;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned QCOUNT_W = 4;
	localparam int unsigned RES_W    = 8;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1667;

	// Item kinds carried on the input tuser.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic              is_tick;
		logic [BYTE_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic              push;
		logic [BYTE_W-1:0] push_data;
		logic              pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic [QCOUNT_W-1:0] queue_count;
		logic                busy_res;
		logic                push_accepted;
		logic                tx_line;
	} result_t;

endpackage
`default_nettype wire

/* rtl/uart_transmitter_with_fifo_unit.sv */
// Top level of the 8N1 serial transmitter with byte queue.
// Each input item is either a byte push (tuser 0) or one timer tick (tuser 1) and produces
// exactly one result item reporting the line level, whether the push was queued, the busy
// flag and the queue fill. Unless the result stalls, the block takes one item per clock
// cycle: items pass through a two-entry input queue into the transmit engine, which handles
// one item per cycle into a single result register that is refilled in the cycle it is read.
// A frame is a low start bit, eight data bits LSB first and a high stop bit, each lasting
// bit_period ticks (0 acts as 1). bit_period may only be written while no item is in flight.
`default_nettype none
module uart_transmitter_with_fifo_unit #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         bit_period_we,
	input  wire logic [utx_pkg::PERIOD_W-1:0] bit_period,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [utx_pkg::BYTE_W-1:0]   s_tdata,  // [7:0] data_byte
	input  wire logic                         s_tuser,  // [0] cmd
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [0] tx_line, [1] push_accepted, [2] busy_res, [6:3] queue_count, [7] zero
	output logic [utx_pkg::RES_W-1:0]         m_tdata
);
	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	utx_pkg::item_t     item;
	logic               item_valid;
	logic               item_take;
	utx_pkg::fifo_ctl_t fifo_ctl;
	logic [utx_pkg::BYTE_W-1:0] fifo_head;
	logic [CW-1:0]      fifo_count;
	logic               fifo_full;
	utx_pkg::result_t   result;

	utx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	utx_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.head   (fifo_head),
		.count  (fifo_count),
		.full   (fifo_full)
	);

	utx_back #(
		.DEPTH (QUEUE_DEPTH),
		.CW    (CW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bit_period_we (bit_period_we),
		.bit_period    (bit_period),
		.item_valid    (item_valid),
		.item_take     (item_take),
		.item          (item),
		.fifo_ctl      (fifo_ctl),
		.fifo_head     (fifo_head),
		.fifo_count    (fifo_count),
		.fifo_full     (fifo_full),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.result        (result)
	);

	assign m_tdata = {1'b0, result};

endmodule
`default_nettype wire

/* rtl/utx_front.sv */
// Input side: takes items from the stream and holds them in a two-entry queue.
`default_nettype none
module utx_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [utx_pkg::BYTE_W-1:0] s_tdata,
	input  wire logic                       s_tuser,
	output logic                            item_valid,
	input  wire logic                       item_take,
	output utx_pkg::item_t                  item
);
	utx_pkg::item_t slot_q [2];
	logic       wr_idx_q;
	logic       rd_idx_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       take;

	assign s_tready   = (cnt_q != 2'd2);
	assign accept     = s_tvalid && s_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign take       = item_take && item_valid;
	assign item       = slot_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_idx_q].is_tick <= (s_tuser == utx_pkg::CMD_TICK);
			slot_q[wr_idx_q].data    <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) wr_idx_q <= ~wr_idx_q;
			if (take) rd_idx_q <= ~rd_idx_q;
			case ({accept, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/utx_fifo.sv */
// Byte queue: circular memory with a registered head-of-queue read.
`default_nettype none
module utx_fifo #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = 3,
	parameter int unsigned CW    = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire utx_pkg::fifo_ctl_t         ctl,
	output logic [utx_pkg::BYTE_W-1:0]      head,
	output logic [CW-1:0]                   count,
	output logic                            full
);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [utx_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [utx_pkg::BYTE_W-1:0] head_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] rd_next;
	logic [AW-1:0] wr_next;
	logic [CW-1:0] cnt_q;

	assign head  = head_q;
	assign count = cnt_q;
	assign full  = (cnt_q == CW'(DEPTH));

	assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
	assign rd_next = !ctl.pop ? rd_ptr_q : ((rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1));

	// The head register always holds the entry at the next read position,
	// taking a byte written there in the same cycle straight from the write.
	always_ff @(posedge clk) begin
		if (ctl.push) mem[wr_ptr_q] <= ctl.push_data;
		if (ctl.push && (wr_ptr_q == rd_next)) begin
			head_q <= ctl.push_data;
		end else begin
			head_q <= mem[rd_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (ctl.push) wr_ptr_q <= wr_next;
			rd_ptr_q <= rd_next;
			case ({ctl.push, ctl.pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/utx_back.sv */
// Transmit engine: bit timer, frame shifter, queue control and result register.
`default_nettype none
module utx_back #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned CW    = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         bit_period_we,
	input  wire logic [utx_pkg::PERIOD_W-1:0] bit_period,
	input  wire logic                         item_valid,
	output logic                              item_take,
	input  wire utx_pkg::item_t               item,
	output utx_pkg::fifo_ctl_t                fifo_ctl,
	input  wire logic [utx_pkg::BYTE_W-1:0]   fifo_head,
	input  wire logic [CW-1:0]                fifo_count,
	input  wire logic                         fifo_full,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output utx_pkg::result_t                  result
);
	logic [utx_pkg::PERIOD_W-1:0] period_q;
	logic [utx_pkg::PERIOD_W-1:0] period_ticks;
	logic [utx_pkg::PERIOD_W-1:0] countdown_q;
	logic [utx_pkg::FRAME_W-1:0]  frame_q;
	logic                         active_q;
	logic                         line_q;
	logic                         out_valid_q;
	utx_pkg::result_t             result_q;

	logic                         fire;
	logic                         do_push;
	logic                         do_tick;
	logic                         boundary;
	logic                         frame_idle;
	logic                         do_pop;
	logic                         go_idle;
	logic                         line_d;
	logic                         active_d;
	logic [CW-1:0]                count_d;

	assign period_ticks = (period_q == '0) ? utx_pkg::PERIOD_W'(1) : period_q;

	assign fire       = item_valid && (!out_valid_q || m_tready);
	assign item_take  = fire;
	assign do_push    = fire && !item.is_tick;
	assign do_tick    = fire && item.is_tick && active_q;
	assign boundary   = do_tick && (countdown_q <= utx_pkg::PERIOD_W'(1));
	assign frame_idle = (frame_q[utx_pkg::FRAME_W-1:1] == '0);
	assign do_pop     = boundary && frame_idle && (fifo_count != '0);
	assign go_idle    = boundary && frame_idle && (fifo_count == '0);

	assign fifo_ctl.push      = do_push && !fifo_full;
	assign fifo_ctl.push_data = item.data;
	assign fifo_ctl.pop       = do_pop;

	always_comb begin
		line_d = line_q;
		if (do_pop) begin
			line_d = 1'b0;
		end else if (boundary && !frame_idle) begin
			line_d = frame_q[0];
		end
	end

	assign active_d = do_push ? 1'b1 : (go_idle ? 1'b0 : active_q);

	always_comb begin
		count_d = fifo_count;
		if (fifo_ctl.push) count_d = fifo_count + CW'(1);
		else if (do_pop) count_d = fifo_count - CW'(1);
	end

	assign m_tvalid = out_valid_q;
	assign result   = result_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.tx_line       <= line_d;
			result_q.push_accepted <= fifo_ctl.push;
			result_q.busy_res      <= active_d;
			result_q.queue_count   <= utx_pkg::QCOUNT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= utx_pkg::PERIOD_RESET;
			countdown_q <= '0;
			frame_q     <= '0;
			active_q    <= 1'b0;
			line_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (bit_period_we) period_q <= bit_period;
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			line_q   <= line_d;
			active_q <= active_d;
			if (do_push && !active_q) begin
				countdown_q <= period_ticks;
			end else if (boundary) begin
				countdown_q <= period_ticks;
			end else if (do_tick) begin
				countdown_q <= countdown_q - utx_pkg::PERIOD_W'(1);
			end
			if (do_pop) begin
				frame_q <= {2'b11, fifo_head};
			end else if (boundary && !frame_idle) begin
				frame_q <= {1'b0, frame_q[utx_pkg::FRAME_W-1:1]};
			end
		end
	end

	// No frame can be in flight while the transmitter is idle.
	a_idle_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> frame_q[utx_pkg::FRAME_W-1:1] == '0)
		else $error("frame pending while idle");

	// A byte is only taken from the queue when one is there.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> fifo_count != '0)
		else $error("pop from empty queue");

	// The queue never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= CW'(DEPTH))
		else $error("queue count overflow");

	// A push into a full queue is reported as not accepted in its result.
	a_refused_push: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && fifo_full |=> !result_q.push_accepted && out_valid_q)
		else $error("push into full queue reported as accepted");

endmodule
`default_nettype wire
